### rtl/core/mbn_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the mesh bounds normalizer
// no dependencies; used by mbn_lane, mbn_finish and mesh_bounds_normalize

package mbn_pkg;

    // command codes carried by an input item
    localparam logic [1:0] CMD_MEASURE   = 2'd0;
    localparam logic [1:0] CMD_FINISH    = 2'd1;
    localparam logic [1:0] CMD_TRANSFORM = 2'd2;

    localparam int TR_W  = 31;          // target radius width
    localparam int NUM_W = TR_W + 16;   // dividend width, target radius in Q16.16 shifted
    localparam int SQ_W  = 64;          // squared span width

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [32:0] R_FLOOR = 33'd66;   // 0.001 rounded up

    // per-cycle control from the sequencer to each axis lane
    typedef struct packed {
        logic measure;      // widen the min/max trackers
        logic first;        // no vertex measured yet
        logic load_pos;     // capture a transform vertex
        logic step_diff;    // magnitude stage
        logic fin_mode;     // magnitude stage works on the span, center updates
        logic step_mul;     // multiply stage
        logic step_sq;      // fold partial products into the square
        logic clear_center; // pass-through finish
    } lane_ctl_t;

endpackage

### rtl/core/mesh_bounds_normalize.sv
`timescale 1ns / 1ps
// top level of the mesh bounds normalizer: sequencer, config register,
// three axis lanes, finish unit and output register; depends on mbn_pkg
//
//  channel   signals                                   dir  handshake
//  in        cmd, pos_x, pos_y, pos_z                  in   in_valid / in_ready
//  out       out_x, out_y, out_z, saturated            out  out_valid / out_ready
//  cfg       cfg_wr_data (target_radius)               in   cfg_wr_en, no wait
//
// measure, unused command and a finish with no measured vertex are done when accepted
// transform steps: capture, magnitude, split multiply, round and clamp
// finish with bounds: span magnitude, square, then the 32-step root and 47-step divide
// one item in flight; the output register holds a result while the next item is
// taken, and a transform waits in its last step while that register is full
// reset (async, active low): empty bounds, center 0, scale one, target radius one

module mesh_bounds_normalize #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [30:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic        saturated
);

    localparam int CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_T_DIFF  = 4'd1;
    localparam logic [3:0] ST_T_MUL   = 4'd2;
    localparam logic [3:0] ST_T_OUT   = 4'd3;
    localparam logic [3:0] ST_F_DIFF  = 4'd4;
    localparam logic [3:0] ST_F_MUL   = 4'd5;
    localparam logic [3:0] ST_F_SQ    = 4'd6;
    localparam logic [3:0] ST_F_START = 4'd7;
    localparam logic [3:0] ST_F_RUN   = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [mbn_pkg::TR_W-1:0] target_radius_reg, target_radius_next;
    logic        seen_any_reg, seen_any_next;
    logic [31:0] scale_reg, scale_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic        sat_reg;

    mbn_pkg::lane_ctl_t ctl;
    logic        accept;
    logic        out_load;
    logic        fin_start;
    logic        fin_done;
    logic [31:0] fin_scale;
    logic [31:0] res_x, res_y, res_z;
    logic        sat_x, sat_y, sat_z;
    logic [mbn_pkg::SQ_W-1:0] sq_x, sq_y, sq_z;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == ST_T_OUT) && (!out_valid_reg || out_ready);
    assign fin_start = (state_reg == ST_F_START);

    always_comb
    begin
        ctl = '0;
        ctl.first        = !seen_any_reg;
        ctl.measure      = accept && (cmd == mbn_pkg::CMD_MEASURE);
        ctl.load_pos     = accept && (cmd == mbn_pkg::CMD_TRANSFORM);
        ctl.clear_center = accept && (cmd == mbn_pkg::CMD_FINISH) && !seen_any_reg;
        ctl.step_diff    = (state_reg == ST_T_DIFF) || (state_reg == ST_F_DIFF);
        ctl.fin_mode     = (state_reg == ST_F_DIFF);
        ctl.step_mul     = (state_reg == ST_T_MUL) || (state_reg == ST_F_MUL);
        ctl.step_sq      = (state_reg == ST_F_SQ);
    end

    always_comb
    begin
        state_next         = state_reg;
        seen_any_next      = seen_any_reg;
        scale_next         = scale_reg;
        target_radius_next = cfg_wr_en ? cfg_wr_data : target_radius_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        mbn_pkg::CMD_MEASURE:
                            seen_any_next = 1'b1;
                        mbn_pkg::CMD_FINISH:
                        begin
                            if (seen_any_reg)
                                state_next = ST_F_DIFF;
                            else
                                scale_next = mbn_pkg::ONE_Q16;
                        end
                        mbn_pkg::CMD_TRANSFORM:
                            state_next = ST_T_DIFF;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_T_DIFF:  state_next = ST_T_MUL;
            ST_T_MUL:   state_next = ST_T_OUT;
            ST_T_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            ST_F_DIFF:  state_next = ST_F_MUL;
            ST_F_MUL:   state_next = ST_F_SQ;
            ST_F_SQ:    state_next = ST_F_START;
            ST_F_START: state_next = ST_F_RUN;
            ST_F_RUN:
            begin
                if (fin_done)
                begin
                    scale_next = fin_scale;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            target_radius_reg <= mbn_pkg::TR_W'(32'd65536);
            seen_any_reg      <= 1'b0;
            scale_reg         <= mbn_pkg::ONE_Q16;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            target_radius_reg <= target_radius_next;
            seen_any_reg      <= seen_any_next;
            scale_reg         <= scale_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // merge the lane results into one item
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg <= res_x;
            out_y_reg <= res_y;
            out_z_reg <= res_z;
            sat_reg   <= sat_x | sat_y | sat_z;
        end
    end

    mbn_lane #(.CW(CW)) u_lane_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pos   (pos_x),
        .scale (scale_reg),
        .res   (res_x),
        .sat   (sat_x),
        .sq    (sq_x)
    );

    mbn_lane #(.CW(CW)) u_lane_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pos   (pos_y),
        .scale (scale_reg),
        .res   (res_y),
        .sat   (sat_y),
        .sq    (sq_y)
    );

    mbn_lane #(.CW(CW)) u_lane_z (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pos   (pos_z),
        .scale (scale_reg),
        .res   (res_z),
        .sat   (sat_z),
        .sq    (sq_z)
    );

    mbn_finish u_finish (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (fin_start),
        .sq_x          (sq_x),
        .sq_y          (sq_y),
        .sq_z          (sq_z),
        .target_radius (target_radius_reg),
        .done          (fin_done),
        .scale         (fin_scale)
    );

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign saturated = sat_reg;

endmodule

### rtl/core/mbn_lane.sv
`timescale 1ns / 1ps
// one axis lane: min/max tracking, center, difference magnitude,
// split multiply and clamp; depends on mbn_pkg

module mbn_lane #(
    parameter int CW = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mbn_pkg::lane_ctl_t      ctl,
    input  logic [31:0]             pos,
    input  logic [31:0]             scale,
    output logic [31:0]             res,
    output logic                    sat,
    output logic [mbn_pkg::SQ_W-1:0] sq
);

    localparam int PW = CW + 16;
    localparam int QW = CW + 17;
    localparam logic [QW-1:0] POS_LIM = QW'((65'd1 << (CW - 1)) - 65'd1);
    localparam logic [QW-1:0] NEG_LIM = QW'(65'd1 << (CW - 1));
    localparam logic signed [CW-1:0] VAL_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] VAL_MIN = {1'b1, {(CW - 1){1'b0}}};

    logic signed [CW-1:0] p_in;
    logic signed [CW-1:0] lo_reg, lo_next;
    logic signed [CW-1:0] hi_reg, hi_next;
    logic signed [CW-1:0] center_reg, center_next;
    logic signed [CW-1:0] p_reg;
    logic [CW-1:0]        mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          op_reg, op_next;
    logic [PW-1:0]        ph_reg, pl_reg;
    logic [mbn_pkg::SQ_W-1:0] sq_reg;

    logic signed [CW:0] mid_sum;
    logic signed [CW:0] span;
    logic signed [CW:0] diff;
    logic [CW:0]        diff_abs;
    logic [QW-1:0]      q;
    logic [QW-1:0]      qn;
    logic signed [CW-1:0] r;

    assign p_in = pos[CW-1:0];

    // bounds trackers
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctl.measure)
        begin
            if (ctl.first)
            begin
                lo_next = p_in;
                hi_next = p_in;
            end
            else
            begin
                if (p_in < lo_reg)
                    lo_next = p_in;
                if (p_in > hi_reg)
                    hi_next = p_in;
            end
        end
    end

    // floor of the midpoint
    assign mid_sum = (CW + 1)'(lo_reg) + (CW + 1)'(hi_reg);
    assign span    = (CW + 1)'(hi_reg) - (CW + 1)'(lo_reg);
    assign diff    = (CW + 1)'(p_reg) - (CW + 1)'(center_reg);
    assign diff_abs = diff[CW] ? -diff : diff;

    always_comb
    begin
        center_next = center_reg;
        if (ctl.clear_center)
            center_next = '0;
        else if (ctl.step_diff && ctl.fin_mode)
            center_next = mid_sum[CW:1];
    end

    always_comb
    begin
        if (ctl.fin_mode)
        begin
            mag_next = span[CW-1:0];
            neg_next = 1'b0;
            op_next  = 32'(span[CW-1:0]);
        end
        else
        begin
            mag_next = diff_abs[CW-1:0];
            neg_next = diff[CW];
            op_next  = scale;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg     <= '0;
            hi_reg     <= '0;
            center_reg <= '0;
        end
        else
        begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            center_reg <= center_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_pos)
            p_reg <= p_in;
        if (ctl.step_diff)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            op_reg  <= op_next;
        end
        // operand split in 16-bit halves keeps each product narrow
        if (ctl.step_mul)
        begin
            ph_reg <= PW'(mag_reg) * PW'(op_reg[31:16]);
            pl_reg <= PW'(mag_reg) * PW'(op_reg[15:0]);
        end
        if (ctl.step_sq)
            sq_reg <= (mbn_pkg::SQ_W'(ph_reg) << 16) + mbn_pkg::SQ_W'(pl_reg);
    end

    // product shifted down by 16, rounded toward minus infinity, then clamped
    assign q  = QW'(ph_reg) + QW'(pl_reg >> 16);
    assign qn = q + QW'(pl_reg[15:0] != 16'd0);

    always_comb
    begin
        sat = 1'b0;
        if (neg_reg)
        begin
            if (qn > NEG_LIM)
            begin
                sat = 1'b1;
                r   = VAL_MIN;
            end
            else
                r = -qn[CW-1:0];
        end
        else
        begin
            if (q > POS_LIM)
            begin
                sat = 1'b1;
                r   = VAL_MAX;
            end
            else
                r = q[CW-1:0];
        end
    end

    assign res = 32'(r);
    assign sq  = sq_reg;

endmodule

### rtl/core/mbn_finish.sv
`timescale 1ns / 1ps
// finish unit: merges the three lane squares, takes an iterative
// square root and a restoring divide for the scale; depends on mbn_pkg

module mbn_finish (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mbn_pkg::SQ_W-1:0]  sq_x,
    input  logic [mbn_pkg::SQ_W-1:0]  sq_y,
    input  logic [mbn_pkg::SQ_W-1:0]  sq_z,
    input  logic [mbn_pkg::TR_W-1:0]  target_radius,
    output logic                      done,
    output logic [31:0]               scale
);

    localparam logic [2:0] FS_IDLE = 3'd0;
    localparam logic [2:0] FS_SQRT = 3'd1;
    localparam logic [2:0] FS_PREP = 3'd2;
    localparam logic [2:0] FS_DIV  = 3'd3;
    localparam logic [2:0] FS_DONE = 3'd4;
    localparam int CNT_W = $clog2(mbn_pkg::NUM_W);
    localparam logic [32:0] R_FLOOR_W = mbn_pkg::R_FLOOR;

    logic [2:0]  state_reg, state_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] bit_reg, bit_next;
    logic [32:0] den_reg, den_next;
    logic [mbn_pkg::NUM_W-1:0] num_reg, num_next;
    logic [mbn_pkg::NUM_W-1:0] quot_reg, quot_next;
    logic [32:0] drem_reg, drem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [65:0] sum;
    logic [63:0] trial;
    logic [33:0] dtrial;
    logic        dge;

    assign sum    = 66'(sq_x) + 66'(sq_y) + 66'(sq_z);
    assign trial  = root_reg + bit_reg;
    assign dtrial = {drem_reg, num_reg[mbn_pkg::NUM_W-1]};
    assign dge    = dtrial >= 34'(den_reg);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        quot_next  = quot_reg;
        drem_next  = drem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (start)
                begin
                    rem_next   = sum[65:2];
                    root_next  = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = FS_SQRT;
                end
            end
            FS_SQRT:
            begin
                // one result bit per cycle
                if (rem_reg >= trial)
                begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                    state_next = FS_PREP;
            end
            FS_PREP:
            begin
                den_next   = (root_reg < 64'(R_FLOOR_W)) ? mbn_pkg::R_FLOOR : root_reg[32:0];
                num_next   = {target_radius, 16'd0};
                quot_next  = '0;
                drem_next  = '0;
                cnt_next   = CNT_W'(mbn_pkg::NUM_W - 1);
                state_next = FS_DIV;
            end
            FS_DIV:
            begin
                if (dge)
                    drem_next = 33'(dtrial - 34'(den_reg));
                else
                    drem_next = dtrial[32:0];
                quot_next = {quot_reg[mbn_pkg::NUM_W-2:0], dge};
                num_next  = num_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = FS_DONE;
            end
            FS_DONE:
                state_next = FS_IDLE;
            default:
                state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        drem_reg <= drem_next;
        cnt_reg  <= cnt_next;
    end

    assign done  = (state_reg == FS_DONE);
    assign scale = (quot_reg > mbn_pkg::NUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                              : quot_reg[31:0];

endmodule
